[hw/rtl/bfe_pkg.sv]
package bfe_pkg;

  // Field and register widths
  localparam int GENE_W     = 32;
  localparam int IDX_W      = $clog2(GENE_W);
  localparam int LEN_W      = 6;
  localparam int FIT_W      = 22;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int MODE_W     = 3;

  // Segment geometry
  localparam int SEG_LEN  = 4;
  localparam int SEG_STEP = 3;
  localparam int NUM_SEG  = (GENE_W + SEG_LEN - 1) / SEG_LEN;
  localparam int NUM_CYC  = (GENE_W + SEG_STEP - 1) / SEG_STEP;

  // Internal widths
  localparam int CNT_W   = 3;
  localparam int POP_W   = 6;
  localparam int SCORE_W = FRAC_BITS + 3;
  localparam int SUM_W   = FIT_W;

  // Reciprocal for the whole-string trap quotient
  localparam int QUO_SHIFT = 29;
  localparam int RECIP_W   = QUO_SHIFT + 1;
  localparam int V3_W      = 8;
  localparam int PROD_W    = V3_W + RECIP_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ONEMAX       = 3'd0,
    MODE_TRAP         = 3'd1,
    MODE_NIAH         = 3'd2,
    MODE_CTRAP        = 3'd3,
    MODE_CNIAH        = 3'd4,
    MODE_CYCTRAP      = 3'd5,
    MODE_LEADINGONES  = 3'd6,
    MODE_LEADINGTRAPS = 3'd7
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'd1;

  typedef struct packed {
    mode_t             mode;
    logic [LEN_W-1:0]  len;   // saturated gene count, 0..GENE_W
  } cfg_t;

  // Trap score of a short segment with m genes and u ones
  function automatic logic [SCORE_W-1:0] trap_seg(input logic [CNT_W-1:0] m,
                                                  input logic [CNT_W-1:0] u);
    logic [SCORE_W-1:0] s;
    s = '0;
    if (m == '0) begin
      s = '0;
    end else if (u == m) begin
      s = SCORE_W'(4) << FRAC_BITS;
    end else if (u == '0) begin
      s = SCORE_W'(3) << FRAC_BITS;
    end else if (m == CNT_W'(SEG_LEN)) begin
      s = SCORE_W'(CNT_W'(3) - u) << FRAC_BITS;
    end else if (m == CNT_W'(3) && u == CNT_W'(1)) begin
      s = SCORE_W'(3) << (FRAC_BITS - 1);
    end
    return s;
  endfunction

  function automatic logic [SCORE_W-1:0] niah_seg(input logic [CNT_W-1:0] m,
                                                  input logic [CNT_W-1:0] u);
    logic [SCORE_W-1:0] s;
    s = '0;
    if (m != '0 && u == m) begin
      s = SCORE_W'(1) << FRAC_BITS;
    end
    return s;
  endfunction

endpackage

[hw/rtl/benchmark_fitness_evaluator.sv]
// Five register stages (align, count, score, sum/multiply, output) lie between an accepted
// input beat and its result beat on the output. Throughput: one chromosome per cycle while
// out_ready stays high; each stage holds one item and advances independently under backpressure.
// Reset (rst_n low, synchronous) empties the pipeline and sets mode to onemax and
// chrom_length to 32. The configuration port is always ready.
module benchmark_fitness_evaluator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bfe_pkg::GENE_W-1:0]           in_genes,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bfe_pkg::FIT_W-1:0]            out_fitness,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bfe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bfe_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  bfe_pkg::mode_t                mode_r;
  logic [bfe_pkg::LEN_W-1:0]     chrom_length_r;
  bfe_pkg::cfg_t                 cfg;

  logic                                                   a_vld, a_rdy;
  logic [bfe_pkg::GENE_W-1:0]                             a_genes;
  logic                                                   c_vld, c_rdy;
  logic [bfe_pkg::NUM_SEG-1:0][bfe_pkg::CNT_W-1:0]        c_ones;
  logic [bfe_pkg::NUM_SEG-1:0][bfe_pkg::CNT_W-1:0]        c_lead;
  logic [bfe_pkg::NUM_CYC-1:0][bfe_pkg::CNT_W-1:0]        c_cyc;
  logic                                                   s_vld, s_rdy;
  logic [bfe_pkg::NUM_CYC-1:0][bfe_pkg::SCORE_W-1:0]      s_lane;
  logic [bfe_pkg::POP_W-1:0]                              s_pop;
  logic [bfe_pkg::POP_W-1:0]                              s_lead;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= bfe_pkg::MODE_ONEMAX;
      chrom_length_r <= bfe_pkg::LEN_W'(bfe_pkg::GENE_W);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bfe_pkg::CFG_MODE:   mode_r <= bfe_pkg::mode_t'(cfg_wdata[bfe_pkg::MODE_W-1:0]);
        bfe_pkg::CFG_LENGTH: chrom_length_r <= cfg_wdata[bfe_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to the gene word
  assign cfg.mode = mode_r;
  assign cfg.len  = (chrom_length_r > bfe_pkg::LEN_W'(bfe_pkg::GENE_W)) ?
                    bfe_pkg::LEN_W'(bfe_pkg::GENE_W) : chrom_length_r;

  bfe_align u_align (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .vld_i   (in_valid),
    .rdy_o   (in_ready),
    .genes_i (in_genes),
    .vld_o   (a_vld),
    .rdy_i   (a_rdy),
    .genes_o (a_genes)
  );

  bfe_count u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .vld_i   (a_vld),
    .rdy_o   (a_rdy),
    .genes_i (a_genes),
    .vld_o   (c_vld),
    .rdy_i   (c_rdy),
    .ones_o  (c_ones),
    .lead_o  (c_lead),
    .cyc_o   (c_cyc)
  );

  bfe_score u_score (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .vld_i  (c_vld),
    .rdy_o  (c_rdy),
    .ones_i (c_ones),
    .lead_i (c_lead),
    .cyc_i  (c_cyc),
    .vld_o  (s_vld),
    .rdy_i  (s_rdy),
    .lane_o (s_lane),
    .pop_o  (s_pop),
    .lead_o (s_lead)
  );

  bfe_reduce u_reduce (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .vld_i  (s_vld),
    .rdy_o  (s_rdy),
    .lane_i (s_lane),
    .pop_i  (s_pop),
    .lead_i (s_lead),
    .vld_o  (out_valid),
    .rdy_i  (out_ready),
    .fit_o  (out_fitness)
  );

endmodule

[hw/rtl/bfe_align.sv]
module bfe_align (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfe_pkg::cfg_t                 cfg,
  input  logic                          vld_i,
  output logic                          rdy_o,
  input  logic [bfe_pkg::GENE_W-1:0]    genes_i,
  output logic                          vld_o,
  input  logic                          rdy_i,
  output logic [bfe_pkg::GENE_W-1:0]    genes_o
);

  logic                        vld_r;
  logic [bfe_pkg::GENE_W-1:0]  al_r;
  logic [bfe_pkg::GENE_W-1:0]  al_nxt;
  logic [bfe_pkg::LEN_W-1:0]   shamt;

  assign rdy_o = !vld_r || rdy_i;

  // Left-align so gene k sits at bit GENE_W-1-k; unused low bits become zero
  assign shamt  = bfe_pkg::LEN_W'(bfe_pkg::GENE_W) - cfg.len;
  assign al_nxt = genes_i << shamt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      al_r <= al_nxt;
    end
  end

  assign vld_o   = vld_r;
  assign genes_o = al_r;

endmodule

[hw/rtl/bfe_count.sv]
module bfe_count (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  bfe_pkg::cfg_t                                          cfg,
  input  logic                                                   vld_i,
  output logic                                                   rdy_o,
  input  logic [bfe_pkg::GENE_W-1:0]                             genes_i,
  output logic                                                   vld_o,
  input  logic                                                   rdy_i,
  output logic [bfe_pkg::NUM_SEG-1:0][bfe_pkg::CNT_W-1:0]        ones_o,
  output logic [bfe_pkg::NUM_SEG-1:0][bfe_pkg::CNT_W-1:0]        lead_o,
  output logic [bfe_pkg::NUM_CYC-1:0][bfe_pkg::CNT_W-1:0]        cyc_o
);

  logic                                              vld_r;
  logic [bfe_pkg::NUM_SEG-1:0][bfe_pkg::CNT_W-1:0]   ones_r, ones_nxt;
  logic [bfe_pkg::NUM_SEG-1:0][bfe_pkg::CNT_W-1:0]   lead_r, lead_nxt;
  logic [bfe_pkg::NUM_CYC-1:0][bfe_pkg::CNT_W-1:0]   cyc_r, cyc_nxt;
  logic [bfe_pkg::SEG_LEN-1:0]                       nib;
  logic                                              run;
  logic                                              g;
  logic [bfe_pkg::LEN_W:0]                           dw;

  assign rdy_o = !vld_r || rdy_i;

  // Per-nibble ones and leading ones
  always_comb begin
    ones_nxt = '0;
    lead_nxt = '0;
    nib      = '0;
    run      = 1'b0;
    for (int j = 0; j < bfe_pkg::NUM_SEG; j++) begin
      nib = genes_i[bfe_pkg::GENE_W-1-bfe_pkg::SEG_LEN*j -: bfe_pkg::SEG_LEN];
      run = 1'b1;
      for (int t = 0; t < bfe_pkg::SEG_LEN; t++) begin
        ones_nxt[j] = ones_nxt[j] + bfe_pkg::CNT_W'(nib[bfe_pkg::SEG_LEN-1-t]);
        run         = run & nib[bfe_pkg::SEG_LEN-1-t];
        lead_nxt[j] = lead_nxt[j] + bfe_pkg::CNT_W'(run);
      end
    end
  end

  // Overlapping segments; genes past the end wrap to the head of the string
  always_comb begin
    cyc_nxt = '0;
    g       = 1'b0;
    dw      = '0;
    for (int c = 0; c < bfe_pkg::NUM_CYC; c++) begin
      for (int t = 0; t < bfe_pkg::SEG_LEN; t++) begin
        dw = (bfe_pkg::LEN_W+1)'(bfe_pkg::SEG_STEP*c + t) - {1'b0, cfg.len};
        if ((bfe_pkg::LEN_W+1)'(bfe_pkg::SEG_STEP*c + t) < {1'b0, cfg.len}) begin
          g = genes_i[bfe_pkg::IDX_W'(bfe_pkg::GENE_W-1-(bfe_pkg::SEG_STEP*c + t))];
        end else begin
          case (dw)
            (bfe_pkg::LEN_W+1)'(0): g = genes_i[bfe_pkg::GENE_W-1];
            (bfe_pkg::LEN_W+1)'(1): g = genes_i[bfe_pkg::GENE_W-2];
            (bfe_pkg::LEN_W+1)'(2): g = genes_i[bfe_pkg::GENE_W-3];
            default:                g = 1'b0;
          endcase
        end
        cyc_nxt[c] = cyc_nxt[c] + bfe_pkg::CNT_W'(g);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      ones_r <= ones_nxt;
      lead_r <= lead_nxt;
      cyc_r  <= cyc_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign ones_o = ones_r;
  assign lead_o = lead_r;
  assign cyc_o  = cyc_r;

endmodule

[hw/rtl/bfe_score.sv]
module bfe_score (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  bfe_pkg::cfg_t                                          cfg,
  input  logic                                                   vld_i,
  output logic                                                   rdy_o,
  input  logic [bfe_pkg::NUM_SEG-1:0][bfe_pkg::CNT_W-1:0]        ones_i,
  input  logic [bfe_pkg::NUM_SEG-1:0][bfe_pkg::CNT_W-1:0]        lead_i,
  input  logic [bfe_pkg::NUM_CYC-1:0][bfe_pkg::CNT_W-1:0]        cyc_i,
  output logic                                                   vld_o,
  input  logic                                                   rdy_i,
  output logic [bfe_pkg::NUM_CYC-1:0][bfe_pkg::SCORE_W-1:0]      lane_o,
  output logic [bfe_pkg::POP_W-1:0]                              pop_o,
  output logic [bfe_pkg::POP_W-1:0]                              lead_o
);

  logic                                                vld_r;
  logic [bfe_pkg::NUM_CYC-1:0][bfe_pkg::SCORE_W-1:0]   lane_r, lane_nxt;
  logic [bfe_pkg::POP_W-1:0]                           pop_r, pop_nxt;
  logic [bfe_pkg::POP_W-1:0]                           lead_r, lead_nxt;
  logic [bfe_pkg::NUM_SEG-1:0][bfe_pkg::CNT_W-1:0]     seg_m;
  logic [bfe_pkg::NUM_SEG-1:0]                         seg_run;
  logic [bfe_pkg::NUM_CYC-1:0][bfe_pkg::CNT_W-1:0]     cyc_m;
  logic [bfe_pkg::NUM_CYC-1:0]                         cyc_in;
  logic [bfe_pkg::LEN_W:0]                             len_x;
  logic [bfe_pkg::LEN_W:0]                             rem;
  logic                                                run;

  assign rdy_o = !vld_r || rdy_i;
  assign len_x = {1'b0, cfg.len};

  // Segment sizes, run-of-full-segments prefix, totals
  always_comb begin
    seg_m    = '0;
    seg_run  = '0;
    pop_nxt  = '0;
    lead_nxt = '0;
    rem      = '0;
    run      = 1'b1;
    for (int j = 0; j < bfe_pkg::NUM_SEG; j++) begin
      rem = len_x - (bfe_pkg::LEN_W+1)'(bfe_pkg::SEG_LEN*j);
      if (len_x >= (bfe_pkg::LEN_W+1)'(bfe_pkg::SEG_LEN*(j+1))) begin
        seg_m[j] = bfe_pkg::CNT_W'(bfe_pkg::SEG_LEN);
      end else if (len_x > (bfe_pkg::LEN_W+1)'(bfe_pkg::SEG_LEN*j)) begin
        seg_m[j] = bfe_pkg::CNT_W'(rem);
      end
      seg_run[j] = run;
      run        = run && (seg_m[j] != '0) && (ones_i[j] == seg_m[j]);
      pop_nxt    = pop_nxt + bfe_pkg::POP_W'(ones_i[j]);
      if (seg_run[j]) begin
        lead_nxt = lead_nxt + bfe_pkg::POP_W'(lead_i[j]);
      end
    end
  end

  // Overlapping segments: gene count after wrap, and whether the segment is scored
  always_comb begin
    cyc_m  = '0;
    cyc_in = '0;
    for (int c = 0; c < bfe_pkg::NUM_CYC; c++) begin
      cyc_in[c] = (bfe_pkg::LEN_W+1)'(bfe_pkg::SEG_STEP*c) < len_x;
      for (int t = 0; t < bfe_pkg::SEG_LEN; t++) begin
        if ((bfe_pkg::LEN_W+1)'(bfe_pkg::SEG_STEP*c + t) < {cfg.len, 1'b0}) begin
          cyc_m[c] = cyc_m[c] + bfe_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    lane_nxt = '0;
    for (int k = 0; k < bfe_pkg::NUM_CYC; k++) begin
      case (cfg.mode)
        bfe_pkg::MODE_CTRAP: begin
          if (k < bfe_pkg::NUM_SEG) begin
            lane_nxt[k] = bfe_pkg::trap_seg(seg_m[k], ones_i[k]);
          end
        end
        bfe_pkg::MODE_CNIAH: begin
          if (k < bfe_pkg::NUM_SEG) begin
            lane_nxt[k] = bfe_pkg::niah_seg(seg_m[k], ones_i[k]);
          end
        end
        bfe_pkg::MODE_LEADINGTRAPS: begin
          if (k < bfe_pkg::NUM_SEG && seg_run[k]) begin
            lane_nxt[k] = bfe_pkg::trap_seg(seg_m[k], ones_i[k]);
          end
        end
        bfe_pkg::MODE_CYCTRAP: begin
          if (cyc_in[k]) begin
            lane_nxt[k] = bfe_pkg::trap_seg(cyc_m[k], cyc_i[k]);
          end
        end
        default: lane_nxt[k] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      lane_r <= lane_nxt;
      pop_r  <= pop_nxt;
      lead_r <= lead_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign lane_o = lane_r;
  assign pop_o  = pop_r;
  assign lead_o = lead_r;

endmodule

[hw/rtl/bfe_reduce.sv]
module bfe_reduce (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  bfe_pkg::cfg_t                                          cfg,
  input  logic                                                   vld_i,
  output logic                                                   rdy_o,
  input  logic [bfe_pkg::NUM_CYC-1:0][bfe_pkg::SCORE_W-1:0]      lane_i,
  input  logic [bfe_pkg::POP_W-1:0]                              pop_i,
  input  logic [bfe_pkg::POP_W-1:0]                              lead_i,
  output logic                                                   vld_o,
  input  logic                                                   rdy_i,
  output logic [bfe_pkg::FIT_W-1:0]                              fit_o
);

  localparam int TREE_N = 16;
  localparam int PSHIFT = bfe_pkg::QUO_SHIFT - bfe_pkg::FRAC_BITS;

  // Reciprocals ceil(2^QUO_SHIFT / d) for divisor d = len - 1
  logic [bfe_pkg::RECIP_W-1:0] recip [2**(bfe_pkg::LEN_W-1)];

  assign recip[0] = '0;
  for (genvar d = 1; d < 2**(bfe_pkg::LEN_W-1); d++) begin : g_recip
    localparam longint unsigned RV = ((64'd1 << bfe_pkg::QUO_SHIFT) + d - 1) / d;
    assign recip[d] = bfe_pkg::RECIP_W'(RV);
  end

  // Sum stage
  logic                               s4_vld_r;
  logic                               s4_rdy;
  logic [bfe_pkg::SUM_W-1:0]          sum_r, sum_nxt;
  logic [bfe_pkg::PROD_W-1:0]         prod_r, prod_nxt;
  logic [bfe_pkg::POP_W-1:0]          pop_r;
  logic [bfe_pkg::POP_W-1:0]          lead_r;
  logic [TREE_N-1:0][bfe_pkg::SUM_W-1:0]   t0;
  logic [TREE_N/2-1:0][bfe_pkg::SUM_W-1:0] t1;
  logic [TREE_N/4-1:0][bfe_pkg::SUM_W-1:0] t2;
  logic [TREE_N/8-1:0][bfe_pkg::SUM_W-1:0] t3;
  logic [bfe_pkg::LEN_W-1:0]          dvr;
  logic [bfe_pkg::LEN_W-1:0]          vcnt;
  logic [bfe_pkg::V3_W-1:0]           v3;

  // Output stage
  logic                               out_vld_r;
  logic [bfe_pkg::FIT_W-1:0]          fit_r, fit_nxt;
  logic [bfe_pkg::PROD_W-1:0]         quo;

  assign s4_rdy = !s4_vld_r || !out_vld_r || rdy_i;
  assign rdy_o  = s4_rdy;

  always_comb begin
    t0 = '0;
    for (int i = 0; i < bfe_pkg::NUM_CYC; i++) begin
      t0[i] = bfe_pkg::SUM_W'(lane_i[i]);
    end
    for (int i = 0; i < TREE_N/2; i++) t1[i] = t0[2*i] + t0[2*i+1];
    for (int i = 0; i < TREE_N/4; i++) t2[i] = t1[2*i] + t1[2*i+1];
    for (int i = 0; i < TREE_N/8; i++) t3[i] = t2[2*i] + t2[2*i+1];
    sum_nxt = t3[0] + t3[1];
  end

  // Whole-string trap: 3*(len-1-ones) / (len-1) by reciprocal multiply
  assign dvr      = cfg.len - bfe_pkg::LEN_W'(1);
  assign vcnt     = dvr - pop_i;
  assign v3       = {2'b00, vcnt} + {1'b0, vcnt, 1'b0};
  assign prod_nxt = bfe_pkg::PROD_W'(v3) *
                    bfe_pkg::PROD_W'(recip[dvr[bfe_pkg::LEN_W-2:0]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && vld_i) begin
      sum_r  <= sum_nxt;
      prod_r <= prod_nxt;
      pop_r  <= pop_i;
      lead_r <= lead_i;
    end
  end

  assign quo = prod_r >> PSHIFT;

  always_comb begin
    fit_nxt = '0;
    if (cfg.len != '0) begin
      case (cfg.mode)
        bfe_pkg::MODE_ONEMAX: begin
          fit_nxt = bfe_pkg::FIT_W'(pop_r) << bfe_pkg::FRAC_BITS;
        end
        bfe_pkg::MODE_TRAP: begin
          if (pop_r == cfg.len) begin
            fit_nxt = bfe_pkg::FIT_W'(4) << bfe_pkg::FRAC_BITS;
          end else if (pop_r == '0) begin
            fit_nxt = bfe_pkg::FIT_W'(3) << bfe_pkg::FRAC_BITS;
          end else begin
            fit_nxt = bfe_pkg::FIT_W'(quo);
          end
        end
        bfe_pkg::MODE_NIAH: begin
          if (pop_r == cfg.len) begin
            fit_nxt = bfe_pkg::FIT_W'(1) << bfe_pkg::FRAC_BITS;
          end
        end
        bfe_pkg::MODE_LEADINGONES: begin
          fit_nxt = bfe_pkg::FIT_W'(lead_r) << bfe_pkg::FRAC_BITS;
        end
        default: fit_nxt = sum_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || rdy_i) begin
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_vld_r || rdy_i) && s4_vld_r) begin
      fit_r <= fit_nxt;
    end
  end

  assign vld_o = out_vld_r;
  assign fit_o = fit_r;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned MAX_WAIT     = 18;
  localparam int unsigned TARGET_ITEMS = 800;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LEN_MAX      = (1 << bfe_pkg::LEN_W) - 1;
  localparam longint unsigned TRAP_FULL  = 4;
  localparam longint unsigned TRAP_EMPTY = 3;

  class fitness_scoreboard;
    logic [bfe_pkg::MODE_W-1:0] mode_reg;
    logic [bfe_pkg::LEN_W-1:0]  length_reg;
    logic [bfe_pkg::FIT_W-1:0]  fitness_q[$];
    int unsigned                errors;

    function new();
      mode_reg   = bfe_pkg::MODE_ONEMAX;
      length_reg = bfe_pkg::LEN_W'(bfe_pkg::GENE_W);
      errors     = 0;
    endfunction

    function void write_reg(logic [bfe_pkg::CFG_IDX_W-1:0] index,
                            logic [bfe_pkg::CFG_DATA_W-1:0] data);
      if (index == bfe_pkg::CFG_MODE) begin
        mode_reg = data[bfe_pkg::MODE_W-1:0];
      end else begin
        length_reg = data[bfe_pkg::LEN_W-1:0];
      end
    endfunction

    // gene k of an n-gene chromosome sits at bit n-1-k
    function int unsigned ones_in_run(logic [bfe_pkg::GENE_W-1:0] g, int unsigned n,
                                      int unsigned from, int unsigned cnt);
      int unsigned u, k;
      u = 0;
      for (k = 0; k < cnt; k++) u += g[n - 1 - (from + k)];
      return u;
    endfunction

    function longint unsigned trap_fixed(int unsigned m, int unsigned u);
      if (u == m) return TRAP_FULL << bfe_pkg::FRAC_BITS;
      if (u == 0) return TRAP_EMPTY << bfe_pkg::FRAC_BITS;
      return ((TRAP_EMPTY * (m - 1 - u)) << bfe_pkg::FRAC_BITS) / (m - 1);
    endfunction

    function longint unsigned needle_fixed(int unsigned m, int unsigned u);
      return (u == m) ? (64'd1 << bfe_pkg::FRAC_BITS) : 64'd0;
    endfunction

    function logic [bfe_pkg::FIT_W-1:0] score_chromosome(logic [bfe_pkg::GENE_W-1:0] g);
      int unsigned n, i, m, u, head, tail;
      longint unsigned total, s;
      bit run;
      n = (length_reg > bfe_pkg::GENE_W) ? bfe_pkg::GENE_W : length_reg;
      total = 0;
      if (n == 0) return '0;
      case (bfe_pkg::mode_t'(mode_reg))
        bfe_pkg::MODE_ONEMAX:
          total = 64'(ones_in_run(g, n, 0, n)) << bfe_pkg::FRAC_BITS;
        bfe_pkg::MODE_TRAP:   total = trap_fixed(n, ones_in_run(g, n, 0, n));
        bfe_pkg::MODE_NIAH:   total = needle_fixed(n, ones_in_run(g, n, 0, n));
        bfe_pkg::MODE_CTRAP, bfe_pkg::MODE_CNIAH: begin
          for (i = 0; i < n; i += bfe_pkg::SEG_LEN) begin
            m = (n - i < bfe_pkg::SEG_LEN) ? n - i : bfe_pkg::SEG_LEN;
            u = ones_in_run(g, n, i, m);
            total += (mode_reg == bfe_pkg::MODE_CTRAP) ? trap_fixed(m, u)
                                                       : needle_fixed(m, u);
          end
        end
        bfe_pkg::MODE_CYCTRAP: begin
          for (i = 0; i < n; i += bfe_pkg::SEG_STEP) begin
            if (i + bfe_pkg::SEG_LEN <= n) begin
              m = bfe_pkg::SEG_LEN;
              u = ones_in_run(g, n, i, bfe_pkg::SEG_LEN);
            end else begin
              // wrap around to the head of the chromosome
              head = n - i;
              tail = bfe_pkg::SEG_LEN - head;
              if (tail > n) tail = n;
              m = head + tail;
              u = ones_in_run(g, n, i, head) + ones_in_run(g, n, 0, tail);
            end
            total += trap_fixed(m, u);
            if (i + bfe_pkg::SEG_LEN >= n + (bfe_pkg::SEG_LEN - bfe_pkg::SEG_STEP)) break;
          end
        end
        bfe_pkg::MODE_LEADINGONES: begin
          i = 0;
          while (i < n && g[n - 1 - i]) i++;
          total = 64'(i) << bfe_pkg::FRAC_BITS;
        end
        bfe_pkg::MODE_LEADINGTRAPS: begin
          run = 1'b1;
          for (i = 0; i < n && run; i += bfe_pkg::SEG_LEN) begin
            m = (n - i < bfe_pkg::SEG_LEN) ? n - i : bfe_pkg::SEG_LEN;
            s = trap_fixed(m, ones_in_run(g, n, i, m));
            total += s;
            run = (s == (TRAP_FULL << bfe_pkg::FRAC_BITS));
          end
        end
        default: total = 0;
      endcase
      return bfe_pkg::FIT_W'(total);
    endfunction

    function void note_chromosome(logic [bfe_pkg::GENE_W-1:0] g);
      fitness_q.insert(fitness_q.size(), score_chromosome(g));
    endfunction

    function void check_fitness(logic [bfe_pkg::FIT_W-1:0] actual);
      logic [bfe_pkg::FIT_W-1:0] want;
      if (fitness_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected fitness beat, expected none, actual %0h", $time, actual);
        return;
      end
      want = fitness_q.pop_front();
      if (actual !== want) begin
        errors++;
        $display("%0t: fitness mismatch, expected %0h, actual %0h", $time, want, actual);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic [bfe_pkg::GENE_W-1:0]     in_genes = '0;
  logic                           out_ready = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [bfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bfe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_ready;
  logic                           out_valid;
  logic                           cfg_ready;
  logic [bfe_pkg::FIT_W-1:0]      out_fitness;

  bit                    tx_calm;
  bit                    rx_calm;
  bit                    rx_hold;
  int unsigned           cycle_count = 0;
  fitness_scoreboard     board = new();

  benchmark_fitness_evaluator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_genes    (in_genes),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_fitness (out_fitness),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_chromosome(input logic [bfe_pkg::GENE_W-1:0] g);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_genes <= g;
    do @(posedge clk); while (!in_ready);
    board.note_chromosome(g);
  endtask

  task automatic write_reg(input logic [bfe_pkg::CFG_IDX_W-1:0] index,
                           input logic [bfe_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the input until every pending fitness beat has come back
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.fitness_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input bfe_pkg::mode_t md, input int unsigned len);
    settle_pipeline();
    // upper data bits are don't-care for the mode register
    write_reg(bfe_pkg::CFG_MODE, {3'($urandom_range(0, 7)), md});
    write_reg(bfe_pkg::CFG_LENGTH, bfe_pkg::CFG_DATA_W'(len));
  endtask

  function automatic logic [bfe_pkg::GENE_W-1:0] shape_genes(input int unsigned len);
    logic [bfe_pkg::GENE_W-1:0] g;
    int unsigned n, k, run_len, style, kind;
    g = $urandom;
    n = (len > bfe_pkg::GENE_W) ? bfe_pkg::GENE_W : len;
    style = $urandom_range(0, 9);
    run_len = $urandom_range(0, n);
    kind = 0;
    for (k = 0; k < n; k++) begin
      case (style)
        0, 1: ;
        2: g[n-1-k] = 1'b1;
        3: g[n-1-k] = 1'b0;
        4, 5, 6: begin
          // pick full, empty or mixed per 4-gene segment
          if (k % bfe_pkg::SEG_LEN == 0) kind = $urandom_range(0, 3);
          if (kind < 2) g[n-1-k] = 1'b1;
          else if (kind == 2) g[n-1-k] = 1'b0;
        end
        7, 8: begin
          if (k < run_len) g[n-1-k] = 1'b1;
          else if (k == run_len) g[n-1-k] = 1'b0;
        end
        default: g[n-1-k] = (k != run_len);
      endcase
    end
    return g;
  endfunction

  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_fitness(out_fitness);
    end
  end

  initial begin
    int unsigned sent, batch, len, pick, phase;
    bfe_pkg::mode_t md;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: onemax over all 32 genes
    send_chromosome('0);
    send_chromosome('1);
    send_chromosome(32'h8000_0001);
    apply_config(bfe_pkg::MODE_TRAP, bfe_pkg::GENE_W);
    send_chromosome('1);
    send_chromosome('0);
    send_chromosome(32'h0000_FFFF);
    // unused high bits must not matter
    apply_config(bfe_pkg::MODE_NIAH, 5);
    send_chromosome(32'h0000_001F);
    send_chromosome(32'hFFFF_FFE0);
    send_chromosome(32'hFFFF_FFFE);
    // short last segment, including the half-step trap value
    apply_config(bfe_pkg::MODE_CTRAP, 7);
    send_chromosome(32'h0000_007F);
    send_chromosome(32'h0000_0000);
    send_chromosome(32'h0000_0044);
    apply_config(bfe_pkg::MODE_CNIAH, 0);
    send_chromosome('1);
    // single gene wraps onto itself
    apply_config(bfe_pkg::MODE_CYCTRAP, 1);
    send_chromosome(32'h0000_0001);
    send_chromosome(32'hFFFF_FFFE);
    apply_config(bfe_pkg::MODE_CYCTRAP, LEN_MAX);
    send_chromosome(32'hF0F0_F0F0);
    apply_config(bfe_pkg::MODE_LEADINGONES, bfe_pkg::GENE_W + 1);
    send_chromosome(32'hFFFF_0000);
    apply_config(bfe_pkg::MODE_LEADINGTRAPS, 10);
    send_chromosome(32'h0000_03FF);
    send_chromosome(32'h0000_03EF);

    sent = 0;
    phase = 0;
    while (sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        case ($urandom_range(0, 3))
          0: len = 0;
          1: len = 1;
          2: len = bfe_pkg::GENE_W;
          default: len = LEN_MAX;
        endcase
      end else if (pick == 1) begin
        len = $urandom_range(bfe_pkg::GENE_W + 1, LEN_MAX);
      end else begin
        len = $urandom_range(1, bfe_pkg::GENE_W);
      end
      md = bfe_pkg::mode_t'($urandom_range(0, 7));
      apply_config(md, len);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      batch = $urandom_range(15, 45);
      if (phase == 2) begin
        // stall the output long enough for the pipe to back up
        tx_calm = 1'b1;
        rx_hold = 1'b1;
        batch = 80;
      end
      repeat (batch) begin
        send_chromosome(shape_genes(len));
        sent++;
      end
      phase++;
    end

    settle_pipeline();
    if (board.errors == 0 && board.fitness_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
